// File: sv/mcit_pkg.sv
// Shared types and codes for the multi-channel interval timer.
package mcit_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_CREATED = 2'd1,
    KIND_FULL    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_CRES = 3'b100
  } state_e;

  // One slot-table word.
  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] count;
    logic [31:0] ival;
    logic        rpt;
  } slot_t;

endpackage

// File: sv/mcit_in_if.sv
// Command channel: op, interval and repeat flag.
interface mcit_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] interval;
  logic        repeat_req;

  modport source (output valid, output op, output interval, output repeat_req, input ready);
  modport sink   (input valid, input op, input interval, input repeat_req, output ready);
endinterface

// File: sv/mcit_out_if.sv
// Result channel: kind, channel id and last flag.
interface mcit_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] channel_id;
  logic       last;

  modport source (output valid, output kind, output channel_id, output last, input ready);
  modport sink   (input valid, input kind, input channel_id, input last, output ready);
endinterface

// File: sv/mcit_free_find.sv
// Lowest free slot finder over the active flags.
module mcit_free_find #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned IW           = 4
) (
  input  logic [NUM_CHANNELS-1:0] act_i,
  output logic                    found_o,
  output logic [IW-1:0]           idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!act_i[i]) begin
        found_o = 1'b1;
        idx_o   = IW'(i);
      end
    end
  end

endmodule

// File: sv/multi_channel_interval_timer.sv
// Top level of the multi-channel interval timer.
//
//  channel | dir | payload                       | beats per item
//  in_i    | in  | op, interval, repeat_req      | 1
//  out_o   | out | kind, channel_id, last        | 0 to NUM_CHANNELS
//
// A tick walks the slot memory one slot per cycle while no output stall
// holds it: acceptance, one read per slot through the single read port of
// the slot memory, the evaluate of the top slot when it is active, the close.
// A create claims its slot at acceptance and hands its result to the output
// register from the result state once that register is free; clear and the
// unused op code complete at acceptance.
// Reset clears the active flags, the id counter and all control state; the
// slot memory needs no clearing pass, as only active slots are ever evaluated.
// An expiry is held back one beat so the final one can carry last; the walk
// pauses while that held beat cannot enter a full output register.
module multi_channel_interval_timer import mcit_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcit_in_if.sink    in_i,
  mcit_out_if.source out_o
);

  localparam int unsigned IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned PW = $clog2(NUM_CHANNELS + 1);
  localparam logic [PW-1:0] PtrEnd = PW'(NUM_CHANNELS);

  // Control state
  state_e                  state_q, state_d;
  logic [NUM_CHANNELS-1:0] act_q;
  logic [7:0]              nid_q;
  logic [PW-1:0]           ptr_q;        // next slot to read
  logic                    ev_vld_q;     // rd_q holds an active slot
  logic [IW-1:0]           ev_idx_q;
  logic                    pend_vld_q;   // expiry held back for the last flag
  logic [7:0]              pend_id_q;
  logic                    out_vld_q;

  // Payload
  slot_t      rd_q;
  logic [7:0] cr_id_q;
  kind_e      cr_kind_q;
  kind_e      out_kind_q;
  logic [7:0] out_id_q;
  logic       out_last_q;

  // Slot memory: one word per channel, synchronous read.
  slot_t mem [NUM_CHANNELS];

  logic          in_acc, out_free;
  logic          is_tick, is_create, is_clear;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [31:0]   cnt_inc;
  logic          hit, stall, advance, walk_done;
  logic          eval_go;
  logic          push_pend, push_fin, push_cr;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  slot_t         mem_wd;

  mcit_free_find #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IW           (IW)
  ) u_free_find (
    .act_i   (act_q),
    .found_o (free_found),
    .idx_o   (free_idx)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_tick    = (in_i.op == OP_TICK);
  assign is_create  = (in_i.op == OP_CREATE);
  assign is_clear   = (in_i.op == OP_CLEAR);

  assign out_free = !out_vld_q || out_o.ready;

  // Evaluate stage of the walk
  assign cnt_inc   = rd_q.count + 32'd1;
  assign hit       = ev_vld_q && (cnt_inc == rd_q.ival);
  assign stall     = hit && pend_vld_q && !out_free;
  assign eval_go   = ev_vld_q && !stall;
  assign advance   = (state_q == ST_TICK) && !stall && (ptr_q != PtrEnd);
  assign walk_done = (state_q == ST_TICK) && (ptr_q == PtrEnd) && !ev_vld_q;

  assign push_pend = (state_q == ST_TICK) && hit && pend_vld_q && out_free;
  assign push_fin  = walk_done && pend_vld_q && out_free;
  assign push_cr   = (state_q == ST_CRES) && out_free;

  // Write port: claim on create, write-back during a tick walk.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ev_idx_q;
    mem_wd = rd_q;
    if (state_q == ST_IDLE) begin
      mem_we      = in_acc && is_create && free_found;
      mem_wa      = free_idx;
      mem_wd.id   = nid_q;
      mem_wd.count = '0;
      mem_wd.ival = in_i.interval;
      mem_wd.rpt  = in_i.repeat_req;
    end else begin
      mem_we       = eval_go;
      mem_wd.count = hit ? 32'd0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (advance) begin
      rd_q <= mem[ptr_q[IW-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_tick) begin
          state_d = ST_TICK;
        end else if (in_acc && is_create) begin
          state_d = ST_CRES;
        end
      end
      ST_TICK: begin
        if (walk_done && (!pend_vld_q || out_free)) begin
          state_d = ST_IDLE;
        end
      end
      ST_CRES: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      act_q      <= '0;
      nid_q      <= '0;
      ptr_q      <= '0;
      ev_vld_q   <= 1'b0;
      ev_idx_q   <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_acc && is_tick) begin
        ptr_q    <= '0;
        ev_vld_q <= 1'b0;
      end else if (advance) begin
        ptr_q    <= ptr_q + PW'(1);
        ev_vld_q <= act_q[ptr_q[IW-1:0]];
        ev_idx_q <= ptr_q[IW-1:0];
      end else if (!stall) begin
        ev_vld_q <= 1'b0;
      end

      // Active flags
      if (in_acc && is_clear) begin
        act_q <= '0;
      end else if (in_acc && is_create && free_found) begin
        act_q[free_idx] <= 1'b1;
        nid_q           <= nid_q + 8'd1;
      end else if (eval_go && hit && !rd_q.rpt) begin
        act_q[ev_idx_q] <= 1'b0;
      end

      // Held-back expiry
      if (eval_go && hit) begin
        pend_vld_q <= 1'b1;
      end else if (push_fin) begin
        pend_vld_q <= 1'b0;
      end

      if (push_pend || push_fin || push_cr) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (eval_go && hit) begin
      pend_id_q <= rd_q.id;
    end
    if (in_acc && is_create) begin
      cr_kind_q <= free_found ? KIND_CREATED : KIND_FULL;
      cr_id_q   <= free_found ? nid_q : 8'd0;
    end
    if (push_pend) begin
      out_kind_q <= KIND_EXPIRED;
      out_id_q   <= pend_id_q;
      out_last_q <= 1'b0;
    end else if (push_fin) begin
      out_kind_q <= KIND_EXPIRED;
      out_id_q   <= pend_id_q;
      out_last_q <= 1'b1;
    end else if (push_cr) begin
      out_kind_q <= cr_kind_q;
      out_id_q   <= cr_id_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.channel_id = out_id_q;
  assign out_o.last       = out_last_q;

`ifndef SYNTHESIS
  // No expiry may be left behind once the block is idle.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_vld_q)
    else $error("held expiry left over in idle");

  // The walk only evaluates slots that are still active.
  a_eval_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> act_q[ev_idx_q])
    else $error("evaluating an inactive slot");

  // The final expiry beat of a tick ends the walk.
  a_fin_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fin |=> (state_q == ST_IDLE))
    else $error("walk continued after last beat");

  // The id counter moves only on a successful create.
  a_nid_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nid_q != $past(nid_q)) |-> ((state_q == ST_CRES) && (cr_kind_q == KIND_CREATED)))
    else $error("id counter moved without a create");
`endif

endmodule

// File: tb/sv/multi_channel_interval_timer_checker.sv
// Scoreboard for the interval timer: predicts result beats from accepted commands and checks them.
module multi_channel_interval_timer_checker import mcit_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mcit_in_if   cmd_i,
  mcit_out_if  res_i,
  output int   mismatches_o,
  output int   outstanding_o,
  output int   expiries_o,
  output int   creations_o,
  output int   rejections_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] channel_id;
    logic       last;
  } timer_result_t;

  slot_t                   slot_tab [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] slot_live;
  logic [7:0]              id_next;
  timer_result_t           due_results [$];

  // Advance the shadow slot table by one command and queue the beats it owes.
  task automatic apply_command(input logic [1:0] op, input logic [31:0] ival, input logic rpt);
    int hits;
    int free_slot;
    int s;
    hits      = 0;
    free_slot = -1;
    case (op)
      OP_TICK: begin
        for (s = 0; s < NUM_CHANNELS; s++) begin
          if (slot_live[s]) begin
            slot_tab[s].count = slot_tab[s].count + 32'd1;
            if (slot_tab[s].count == slot_tab[s].ival) begin
              slot_tab[s].count = '0;
              due_results.push_back(timer_result_t'{KIND_EXPIRED, slot_tab[s].id, 1'b0});
              hits++;
              if (!slot_tab[s].rpt) slot_live[s] = 1'b0;
            end
          end
        end
        if (hits > 0) due_results[due_results.size() - 1].last = 1'b1;
      end
      OP_CREATE: begin
        for (s = NUM_CHANNELS - 1; s >= 0; s--) begin
          if (!slot_live[s]) free_slot = s;
        end
        if (free_slot >= 0) begin
          slot_live[free_slot]     = 1'b1;
          slot_tab[free_slot].id    = id_next;
          slot_tab[free_slot].count = '0;
          slot_tab[free_slot].ival  = ival;
          slot_tab[free_slot].rpt   = rpt;
          due_results.push_back(timer_result_t'{KIND_CREATED, id_next, 1'b1});
          id_next = id_next + 8'd1;
        end else begin
          due_results.push_back(timer_result_t'{KIND_FULL, 8'd0, 1'b1});
        end
      end
      OP_CLEAR: slot_live = '0;
      default: ;  // unused code: no effect
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t want;
    if (!rst_ni) begin
      slot_live     = '0;
      id_next       = '0;
      due_results.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      expiries_o    = 0;
      creations_o   = 0;
      rejections_o  = 0;
    end else begin
      // predict first, so a beat owed by this very command could still be matched
      if (cmd_i.valid && cmd_i.ready) apply_command(cmd_i.op, cmd_i.interval, cmd_i.repeat_req);
      if (res_i.valid && res_i.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat with none expected: got kind %0d id %0d last %0d",
                   $time, res_i.kind, res_i.channel_id, res_i.last);
          mismatches_o++;
        end else begin
          want = due_results.pop_front();
          if (res_i.kind !== want.kind || res_i.channel_id !== want.channel_id ||
              res_i.last !== want.last) begin
            $display("%0t: result mismatch: expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                     $time, want.kind, want.channel_id, want.last,
                     res_i.kind, res_i.channel_id, res_i.last);
            mismatches_o++;
          end
          case (want.kind)
            KIND_EXPIRED: expiries_o++;
            KIND_CREATED: creations_o++;
            default:      rejections_o++;
          endcase
        end
      end
      outstanding_o = due_results.size();
    end
  end

endmodule

// File: tb/sv/multi_channel_interval_timer_test.sv
// Testbench top for the interval timer: command stimulus, result back-pressure and the verdict.
module multi_channel_interval_timer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mcit_pkg::*;

  localparam int unsigned NUM_CHANNELS = 16;
  localparam int          PHASE_ITEMS  = 45;      // counted commands per idling phase
  localparam int          HOLD_CYCLES  = 300;     // long result stall, fills the block
  localparam int          DRAIN_CYCLES = 2 * NUM_CHANNELS + 8;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;    // op code the block must ignore

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int tx_idle_pct = 0;    // chance in a hundred that the sender skips a cycle
  int rx_idle_pct = 0;    // chance in a hundred that the receiver drops ready
  bit hold_req    = 1'b0; // asks the receiver for one long stall
  int sent        = 0;    // accepted commands, ignored op code not counted
  int cycles      = 0;
  int mismatches, outstanding, expiries, creations, rejections;

  mcit_in_if  cmd_if ();
  mcit_out_if res_if ();

  multi_channel_interval_timer #(.NUM_CHANNELS(NUM_CHANNELS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  multi_channel_interval_timer_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_if),
    .res_i         (res_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .expiries_o    (expiries),
    .creations_o   (creations),
    .rejections_o  (rejections)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: generous bound on the slowest legal run, stalls included.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d beats still owed", cycles, outstanding);
      $display("multi_channel_interval_timer test failed");
      $finish;
    end
  end

  // Result side: ready moves on the falling edge only. A hold request turns into
  // a long stretch with ready low, counted here, while commands keep coming.
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // One command beat: optional idle cycles, then hold valid until the beat is taken.
  task automatic send_command(input logic [1:0] op, input logic [31:0] ival, input logic rpt);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.op         <= op;
    cmd_if.interval   <= ival;
    cmd_if.repeat_req <= rpt;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    if (op != OP_UNUSED) sent++;
  endtask

  // Mostly short intervals so channels really expire; a share of full-width
  // values so every interval bit toggles, plus both extremes now and then.
  function automatic logic [31:0] pick_interval();
    int r;
    r = $urandom_range(99);
    if (r < 70)      return $urandom_range(6, 1);
    else if (r < 80) return $urandom_range(40, 7);
    else if (r < 90) return $urandom();
    else if (r < 95) return 32'd0;
    else             return 32'hFFFF_FFFF;
  endfunction

  // Random mix: ticks and creates dominate; clears and the dead op code are rare.
  // Tick and clear beats still carry random payload, which must be ignored.
  task automatic send_random_command();
    int r;
    r = $urandom_range(99);
    if (r < 8)       send_command(OP_CLEAR, $urandom(), 1'($urandom_range(1)));
    else if (r < 12) send_command(OP_UNUSED, $urandom(), 1'($urandom_range(1)));
    else if (r < 52) send_command(OP_TICK, $urandom(), 1'($urandom_range(1)));
    else             send_command(OP_CREATE, pick_interval(), 1'($urandom_range(1)));
  endtask

  initial begin : stimulus
    int target;
    cmd_if.valid      = 1'b0;
    cmd_if.op         = OP_TICK;
    cmd_if.interval   = '0;
    cmd_if.repeat_req = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // single one-shot channel expiring on the first tick
    send_command(OP_CREATE, 32'd1, 1'b0);
    send_command(OP_TICK, 32'd0, 1'b0);
    // interval extremes: zero stands for a full 2^32 wrap, so neither fires soon
    send_command(OP_CREATE, 32'd0, 1'b1);
    send_command(OP_CREATE, 32'hFFFF_FFFF, 1'b0);
    // tick with nothing due gives no beat at all
    send_command(OP_TICK, 32'hFFFF_FFFF, 1'b1);
    send_command(OP_UNUSED, 32'hA5A5_5A5A, 1'b1);
    send_command(OP_CLEAR, 32'd0, 1'b0);
    // fill every slot, alternating periodic and one-shot, then overflow the table
    for (int i = 0; i < NUM_CHANNELS; i++) send_command(OP_CREATE, 32'd1, i[0]);
    send_command(OP_CREATE, 32'd3, 1'b1);
    // all slots fire together (last on the final beat); only the periodic half reloads
    send_command(OP_TICK, 32'd0, 1'b0);
    send_command(OP_TICK, 32'd0, 1'b0);
    send_command(OP_CLEAR, 32'd0, 1'b0);

    // --- random, three idling phases ---
    target      = sent + PHASE_ITEMS;
    tx_idle_pct = 18;
    rx_idle_pct = 70;
    while (sent < target) send_random_command();

    target      = sent + PHASE_ITEMS;
    tx_idle_pct = 70;
    rx_idle_pct = 18;
    while (sent < target) send_random_command();

    // no idling either side; opens with the long receiver stall so the
    // output backs up and the walk, then the command port, stall behind it
    target      = sent + PHASE_ITEMS;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    while (sent < target) send_random_command();

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;

    // drain owed beats, then let any trailing walk finish
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Drove %0d commands over three idling phases and one long output stall;",
             sent);
    $display("checked %0d expiry, %0d create and %0d table-full beats.",
             expiries, creations, rejections);
    if (mismatches == 0 && outstanding == 0) begin
      $display("multi_channel_interval_timer test passed");
    end else begin
      $display("multi_channel_interval_timer test failed");
    end
    $finish;
  end

endmodule
